@@ design/scda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scda_pkg: shared types and constants
// Item structs, command and actuator codes, and frame layout constants.
// ----------------------------------------------------------------------------
package scda_pkg;

  // Frame layout
  localparam logic [3:0] HEADER_LEN = 4'd5;
  localparam logic [3:0] FRAME_LEN  = 4'd13;
  localparam logic [3:0] POS_START  = 4'd1;

  // Shift command bytes
  localparam logic [7:0] CMD_UP      = 8'h75;  // 'u'
  localparam logic [7:0] CMD_DOWN    = 8'h64;  // 'd'
  localparam logic [7:0] CMD_NEUTRAL = 8'h6E;  // 'n'

  // Reset values
  localparam logic [9:0] PULSE_RESET = 10'd100;
  localparam logic [7:0] GAP_RESET   = 8'd5;
  localparam logic [9:0] START_DELAY = 10'd10;

  // Item operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Config register indexes
  localparam logic REG_PULSE = 1'b0;
  localparam logic REG_GAP   = 1'b1;

  // Actuator selection, one-hot
  typedef enum logic [3:0] {
    ACT_NONE   = 4'b0001,
    ACT_UP     = 4'b0010,
    ACT_DOWN   = 4'b0100,
    ACT_CLUTCH = 4'b1000
  } act_t;

  // Timer phase, one-hot
  typedef enum logic [1:0] {
    PH_GAP   = 2'b01,
    PH_PULSE = 2'b10
  } phase_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       up_air;
    logic       down_air;
    logic       clutch_drive;
    logic [7:0] command_now;
    logic       header_locked;
  } out_item_t;

  // Decoded item handed from front to back
  typedef struct packed {
    logic       is_tick;
    logic [7:0] rx_byte;
    act_t       cmd_act;
  } mid_item_t;

endpackage

@@ design/scda_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scda_fifo: small register queue
// Push/full on the write side, pop/empty on the read side, head shown on dout.
// ----------------------------------------------------------------------------
module scda_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_push_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on lone transfer in");

endmodule

@@ design/scda_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scda_front: item intake and classifier
// Tags each item as byte or tick, pre-decodes the command class, and queues it.
// ----------------------------------------------------------------------------
module scda_front #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  scda_pkg::in_item_t   in_item,
  output logic                 full,
  input  logic                 mid_pop,
  output scda_pkg::mid_item_t  mid_item,
  output logic                 mid_empty
);

  scda_pkg::mid_item_t dec;
  logic [$bits(scda_pkg::mid_item_t)-1:0] mid_raw;

  always_comb begin
    dec.is_tick = (in_item.operation == scda_pkg::OP_TICK);
    dec.rx_byte = in_item.rx_byte;
    case (in_item.rx_byte)
      scda_pkg::CMD_UP:      dec.cmd_act = scda_pkg::ACT_UP;
      scda_pkg::CMD_DOWN:    dec.cmd_act = scda_pkg::ACT_DOWN;
      scda_pkg::CMD_NEUTRAL: dec.cmd_act = scda_pkg::ACT_CLUTCH;
      default:               dec.cmd_act = scda_pkg::ACT_NONE;
    endcase
  end

  scda_fifo #(
    .DEPTH (DEPTH),
    .WIDTH ($bits(scda_pkg::mid_item_t))
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (dec),
    .full  (full),
    .pop   (mid_pop),
    .dout  (mid_raw),
    .empty (mid_empty)
  );

  assign mid_item = scda_pkg::mid_item_t'(mid_raw);

endmodule

@@ design/scda_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scda_back: deframer and actuator timer
// Applies one decoded item per cycle while the status queue has room; queues its status.
// ----------------------------------------------------------------------------
module scda_back #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [9:0]           cfg_wdata,
  output logic                 mid_pop,
  input  scda_pkg::mid_item_t  mid_item,
  input  logic                 mid_empty,
  input  logic                 pop,
  output scda_pkg::out_item_t  out_item,
  output logic                 empty
);

  logic [9:0]       pulse_r;
  logic [7:0]       gap_r;
  logic [3:0]       pos_r, pos_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  scda_pkg::act_t   cls_r, cls_nxt;  // decoded class of stored command
  scda_pkg::act_t   act_r, act_nxt;
  scda_pkg::phase_t phase_r, phase_nxt;
  logic [9:0]       cnt_r, cnt_nxt;
  logic [9:0]       cnt_dec;
  logic             out_full;
  logic             step;
  scda_pkg::out_item_t res;
  logic [$bits(scda_pkg::out_item_t)-1:0] out_raw;

  assign step    = !mid_empty && !out_full;
  assign mid_pop = step;
  assign cnt_dec = (cnt_r != '0) ? cnt_r - 1'b1 : '0;

  always_comb begin
    pos_nxt   = pos_r;
    cmd_nxt   = cmd_r;
    cls_nxt   = cls_r;
    act_nxt   = act_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    if (!mid_item.is_tick) begin
      if (pos_r >= scda_pkg::FRAME_LEN) begin
        pos_nxt = scda_pkg::POS_START;
      end else if (pos_r <= scda_pkg::HEADER_LEN) begin
        pos_nxt = (mid_item.rx_byte == {4'd0, pos_r}) ? pos_r + 1'b1 : scda_pkg::POS_START;
      end else begin
        if (pos_r == scda_pkg::HEADER_LEN + 1'b1) begin
          cmd_nxt = mid_item.rx_byte;
          cls_nxt = mid_item.cmd_act;
        end
        pos_nxt = pos_r + 1'b1;
      end
    end else begin
      cnt_nxt = cnt_dec;
      if (cnt_dec == '0) begin
        if (phase_r == scda_pkg::PH_PULSE) begin
          act_nxt   = scda_pkg::ACT_NONE;
          phase_nxt = scda_pkg::PH_GAP;
          cnt_nxt   = {2'd0, gap_r};
        end else begin
          act_nxt = cls_r;
          if (cls_r != scda_pkg::ACT_NONE) begin
            phase_nxt = scda_pkg::PH_PULSE;
            cnt_nxt   = pulse_r;
          end else begin
            cnt_nxt = {2'd0, gap_r};
          end
        end
      end
    end
  end

  always_comb begin
    res.up_air        = (act_nxt == scda_pkg::ACT_UP);
    res.down_air      = (act_nxt == scda_pkg::ACT_DOWN);
    res.clutch_drive  = (act_nxt == scda_pkg::ACT_CLUTCH);
    res.command_now   = cmd_nxt;
    res.header_locked = (pos_nxt > scda_pkg::HEADER_LEN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r <= scda_pkg::PULSE_RESET;
      gap_r   <= scda_pkg::GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        scda_pkg::REG_PULSE: pulse_r <= cfg_wdata;
        scda_pkg::REG_GAP:   gap_r   <= cfg_wdata[7:0];
        default:             pulse_r <= pulse_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= scda_pkg::POS_START;
      cmd_r   <= '0;
      cls_r   <= scda_pkg::ACT_NONE;
      act_r   <= scda_pkg::ACT_NONE;
      phase_r <= scda_pkg::PH_GAP;
      cnt_r   <= scda_pkg::START_DELAY;
    end else if (step) begin
      pos_r   <= pos_nxt;
      cmd_r   <= cmd_nxt;
      cls_r   <= cls_nxt;
      act_r   <= act_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  scda_fifo #(
    .DEPTH (DEPTH),
    .WIDTH ($bits(scda_pkg::out_item_t))
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (step),
    .din   (res),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_raw),
    .empty (empty)
  );

  assign out_item = scda_pkg::out_item_t'(out_raw);

  a_pulse_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == scda_pkg::PH_PULSE) == (act_r != scda_pkg::ACT_NONE))
    else $error("actuator drive out of step with timer phase");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != '0) && (pos_r <= scda_pkg::FRAME_LEN))
    else $error("frame position out of range");

  a_byte_keeps_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !mid_item.is_tick) |=> ($stable(cnt_r) && $stable(act_r) && $stable(phase_r)))
    else $error("serial byte disturbed the actuator timer");

endmodule

@@ design/shift_command_deframer_actuator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_command_deframer_actuator: serial shift command deframer and timer
// Locks onto framed serial commands and pulses the up, down or clutch drive
// on millisecond ticks.
// ----------------------------------------------------------------------------
//  Channel  | Ports                          | Transfer when
//  ---------+--------------------------------+-------------------------------
//  input    | push, full, in_item            | push && !full
//  result   | pop, empty, out_item           | pop && !empty
//  config   | cfg_we, cfg_addr, cfg_wdata    | cfg_we
//
// One result per input item. An item waits in the front queue until the back
// applies it and writes its result into the result queue, from which it can be
// popped; one item per cycle is sustained while the result side keeps popping.
// Reset (rst_n low, synchronous) empties both queues and loads start-up state.
// A stalled result side fills the output queue, then the front queue, and
// only then raises full.
// ----------------------------------------------------------------------------
module shift_command_deframer_actuator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                push,
  input  scda_pkg::in_item_t  in_item,
  output logic                full,
  // result channel
  input  logic                pop,
  output scda_pkg::out_item_t out_item,
  output logic                empty,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [9:0]          cfg_wdata
);

  // Front to back hand-off
  scda_pkg::mid_item_t mid_item;
  logic                mid_pop;
  logic                mid_empty;

  // Front: tags bytes vs ticks, pre-decodes the command byte class.
  scda_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .mid_pop   (mid_pop),
    .mid_item  (mid_item),
    .mid_empty (mid_empty)
  );

  // Back: frame position counter, command store, pulse/gap countdown,
  // and the result queue.
  scda_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .mid_pop   (mid_pop),
    .mid_item  (mid_item),
    .mid_empty (mid_empty),
    .pop       (pop),
    .out_item  (out_item),
    .empty     (empty)
  );

endmodule

@@ tb/sv/shift_command_deframer_actuator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_command_deframer_actuator_tb: self-checking bench for the deframer
// Drives serial bytes and ticks through the input queue, predicts every
// result with an in-bench model of the deframer and actuator timer, and
// checks each popped result field by field under random idling, a long
// result-side hold and several timing register settings.
// ----------------------------------------------------------------------------
module shift_command_deframer_actuator_tb;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer or register write
  localparam int HOLD_STRETCH   = 300;   // result-side hold for the fill test

  logic                clk;
  logic                rst_n;
  logic                push;
  scda_pkg::in_item_t  in_item;
  logic                full;
  logic                pop;
  scda_pkg::out_item_t out_item;
  logic                empty;
  logic                cfg_we;
  logic                cfg_addr;
  logic [9:0]          cfg_wdata;

  shift_command_deframer_actuator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .pop      (pop),
    .out_item (out_item),
    .empty    (empty),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Drive predictions waiting for their result transfer, oldest first
  scda_pkg::out_item_t expected_drive_q[$];

  int error_count = 0;
  int items_sent  = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;   // set by the fill test, consumed by the result side
  bit no_gaps     = 1'b0; // both sides run back to back while set

  // Bench copy of the block's state and timing registers
  logic [9:0]       pulse_len;
  logic [7:0]       gap_len;
  logic [3:0]       frame_pos;
  logic [7:0]       cmd_store;
  scda_pkg::phase_t timer_phase;
  scda_pkg::act_t   drive;
  logic [9:0]       countdown;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model of the deframer and actuator timer
  // --------------------------------------------------------------------------
  task automatic reset_model();
    pulse_len   = scda_pkg::PULSE_RESET;
    gap_len     = scda_pkg::GAP_RESET;
    frame_pos   = scda_pkg::POS_START;
    cmd_store   = 8'h00;
    timer_phase = scda_pkg::PH_GAP;
    drive       = scda_pkg::ACT_NONE;
    countdown   = scda_pkg::START_DELAY;
  endtask

  // Applies one item to the model and returns the result (drive, command, lock) it leaves
  function automatic scda_pkg::out_item_t advance_actuator(input scda_pkg::in_item_t item);
    scda_pkg::out_item_t res;
    if (item.operation == scda_pkg::OP_BYTE) begin
      if (frame_pos >= scda_pkg::FRAME_LEN) begin
        // frame end: byte dropped, start over
        frame_pos = scda_pkg::POS_START;
      end else if (frame_pos <= scda_pkg::HEADER_LEN) begin
        // header byte must equal its position; a miss is not re-checked as byte 1
        if (item.rx_byte == {4'd0, frame_pos}) frame_pos = frame_pos + 4'd1;
        else frame_pos = scda_pkg::POS_START;
      end else begin
        if (frame_pos == scda_pkg::HEADER_LEN + 4'd1) cmd_store = item.rx_byte;
        frame_pos = frame_pos + 4'd1;
      end
    end else begin
      // zero count acts like one: no decrement, phase ends now
      if (countdown != 10'd0) countdown = countdown - 10'd1;
      if (countdown == 10'd0) begin
        if (timer_phase == scda_pkg::PH_PULSE) begin
          drive       = scda_pkg::ACT_NONE;
          timer_phase = scda_pkg::PH_GAP;
          countdown   = {2'b00, gap_len};
        end else begin
          case (cmd_store)
            scda_pkg::CMD_UP:      drive = scda_pkg::ACT_UP;
            scda_pkg::CMD_DOWN:    drive = scda_pkg::ACT_DOWN;
            scda_pkg::CMD_NEUTRAL: drive = scda_pkg::ACT_CLUTCH;
            default:               drive = scda_pkg::ACT_NONE;
          endcase
          if (drive != scda_pkg::ACT_NONE) begin
            timer_phase = scda_pkg::PH_PULSE;
            countdown   = pulse_len;
          end else begin
            countdown = {2'b00, gap_len};
          end
        end
      end
    end
    res.up_air        = (drive == scda_pkg::ACT_UP);
    res.down_air      = (drive == scda_pkg::ACT_DOWN);
    res.clutch_drive  = (drive == scda_pkg::ACT_CLUTCH);
    res.command_now   = cmd_store;
    res.header_locked = (frame_pos > scda_pkg::HEADER_LEN);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // One input transfer: random lead-in gap, then hold push until !full.
  // push stays high into the next item when its gap is zero.
  task automatic send_item(input logic op, input logic [7:0] data);
    int                 gap_n;
    scda_pkg::in_item_t item;
    gap_n = no_gaps ? 0 : $urandom_range(0, 3);
    item.operation = op;
    item.rx_byte   = data;
    if (gap_n > 0) begin
      push <= 1'b0;
      repeat (gap_n) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (full !== 1'b0);
    expected_drive_q.push_back(advance_actuator(item));
    items_sent++;
  endtask

  // Byte preceded by a random run of ticks (tick byte field is junk)
  task automatic send_byte_mixed(input logic [7:0] data, input int tick_pct);
    while ($urandom_range(0, 99) < tick_pct)
      send_item(scda_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    send_item(scda_pkg::OP_BYTE, data);
  endtask

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 3))
      0:       return scda_pkg::CMD_UP;
      1:       return scda_pkg::CMD_DOWN;
      2:       return scda_pkg::CMD_NEUTRAL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed frames with random content, some broken headers and noise
  task automatic send_frame(input int tick_pct);
    int         kind;
    int         cut;
    logic [7:0] bad;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      for (int i = 1; i <= scda_pkg::HEADER_LEN; i++) send_byte_mixed(8'(i), tick_pct);
      send_byte_mixed(pick_command(), tick_pct);
      for (int i = scda_pkg::HEADER_LEN + 2; i < scda_pkg::FRAME_LEN; i++)
        send_byte_mixed(8'($urandom_range(0, 255)), tick_pct);
      send_byte_mixed(8'($urandom_range(0, 255)), tick_pct);  // frame end, dropped
    end else if (kind < 9) begin
      cut = $urandom_range(1, scda_pkg::HEADER_LEN);
      for (int i = 1; i < cut; i++) send_byte_mixed(8'(i), tick_pct);
      if (cut > 1 && $urandom_range(0, 1)) begin
        bad = 8'd1;  // looks like a header start, must not be taken as one
      end else begin
        do bad = 8'($urandom_range(0, 255)); while (bad == 8'(cut));
      end
      send_byte_mixed(bad, tick_pct);
    end else begin
      repeat ($urandom_range(1, 6)) send_byte_mixed(8'($urandom_range(0, 255)), tick_pct);
    end
  endtask

  // Timing registers change only with nothing in flight
  task automatic set_timing(input logic [9:0] pulse, input logic [7:0] gap);
    push <= 1'b0;
    @(posedge clk);
    while (expected_drive_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= scda_pkg::REG_PULSE;
    cfg_wdata <= pulse;
    @(posedge clk);
    pulse_len = pulse;
    cfg_addr  <= scda_pkg::REG_GAP;
    cfg_wdata <= {2'($urandom_range(0, 3)), gap};  // upper bits are don't-care
    @(posedge clk);
    gap_len = gap;
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random pop idling, optional long hold, field checks
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  initial begin : result_side
    int                  wait_n;
    int                  hold_n;
    scda_pkg::out_item_t want;
    pop <= 1'b0;
    @(posedge clk iff rst_n === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        hold_n      = hold_cycles;
        hold_cycles = 0;
        pop <= 1'b0;
        repeat (hold_n) @(posedge clk);
      end
      wait_n = no_gaps ? 0 : $urandom_range(0, 3);
      if (wait_n > 0) begin
        pop <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      if (expected_drive_q.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_item);
        error_count++;
      end else begin
        want = expected_drive_q.pop_front();
        check_field("up_air", 8'(want.up_air), 8'(out_item.up_air));
        check_field("down_air", 8'(want.down_air), 8'(out_item.down_air));
        check_field("clutch_drive", 8'(want.clutch_drive), 8'(out_item.clutch_drive));
        check_field("command_now", want.command_now, out_item.command_now);
        check_field("header_locked", 8'(want.header_locked), 8'(out_item.header_locked));
      end
    end
  end

  // Watchdog: any transfer or register write restarts the count
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Header miss on a byte equal to 1, then a full frame with byte extremes
  // in the payload and a dropped frame-end byte. Stores 'u'.
  task automatic test_deframer();
    logic [7:0] payload[6];
    payload = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA};
    send_item(scda_pkg::OP_BYTE, 8'd1);
    send_item(scda_pkg::OP_BYTE, 8'd2);
    send_item(scda_pkg::OP_BYTE, 8'd1);  // miss at position 3; position back to 1
    send_item(scda_pkg::OP_BYTE, 8'd2);  // so this one misses too
    for (int i = 1; i <= scda_pkg::HEADER_LEN; i++) send_item(scda_pkg::OP_BYTE, 8'(i));
    send_item(scda_pkg::OP_BYTE, scda_pkg::CMD_UP);
    foreach (payload[i]) send_item(scda_pkg::OP_BYTE, payload[i]);
    send_item(scda_pkg::OP_BYTE, 8'h01);  // frame end
  endtask

  // Start-up delay, a short pulse with a byte inside it, gap, re-sample,
  // then zero-length counts
  task automatic test_actuator_timing();
    set_timing(10'd2, 8'd1);
    repeat (scda_pkg::START_DELAY) send_item(scda_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    send_item(scda_pkg::OP_BYTE, 8'h01);  // during the pulse: drive unchanged
    repeat (3) send_item(scda_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    set_timing(10'd0, 8'd0);
    repeat (4) send_item(scda_pkg::OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Random frames and ticks under one timing setting
  task automatic test_random_traffic(input int n_items, input logic [9:0] pulse,
                                     input logic [7:0] gap, input int tick_pct);
    int target;
    set_timing(pulse, gap);
    target = items_sent + n_items;
    while (items_sent < target) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      send_frame(tick_pct);
    end
    no_gaps = 1'b0;
  endtask

  // Result side holds off while input keeps coming, so full must rise
  task automatic test_fill_stall();
    int target;
    set_timing(10'd3, 8'd2);
    hold_cycles = HOLD_STRETCH;
    no_gaps     = 1'b1;
    target      = items_sent + 40;
    while (items_sent < target) send_frame(50);
    no_gaps = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run
    push      <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= scda_pkg::REG_PULSE;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_deframer();
    test_actuator_timing();
    test_random_traffic(250, scda_pkg::PULSE_RESET, scda_pkg::GAP_RESET, 60);
    test_random_traffic(350, 10'd1, 8'd1, 40);
    test_random_traffic(300, 10'd3, 8'd2, 50);
    test_fill_stall();
    test_random_traffic(200, 10'd1023, 8'd255, 95);  // longest counts
    test_random_traffic(300, 10'd1, 8'd255, 90);     // long gap runs out

    // drain, then allow for pipeline latency before the verdict
    push <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/scda_pkg.sv
design/scda_fifo.sv
design/scda_front.sv
design/scda_back.sv
design/shift_command_deframer_actuator.sv
tb/sv/shift_command_deframer_actuator_tb.sv
